FILE: hdl/assert_macros.svh
// Assertion macros shared by the stack machine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SVCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define SVCE_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: hdl/svce_pkg.sv
// Types, constants and control structs of the stack machine command executor.
package svce_pkg;

  localparam int unsigned MEM_WORDS = 32768;
  localparam int unsigned AW        = $clog2(MEM_WORDS);
  localparam int unsigned DW        = 16;
  localparam int unsigned NPTR      = 5;

  localparam logic [2:0] PTR_SP   = 3'd0;
  localparam logic [2:0] PTR_LCL  = 3'd1;
  localparam logic [2:0] PTR_ARG  = 3'd2;
  localparam logic [2:0] PTR_THIS = 3'd3;
  localparam logic [2:0] PTR_THAT = 3'd4;

  localparam logic [15:0] SP_INIT      = 16'd256;
  localparam logic [15:0] LCL_INIT     = 16'd256;
  localparam logic [15:0] ARG_INIT     = 16'd256;
  localparam logic [15:0] THIS_INIT    = 16'd3000;
  localparam logic [15:0] THAT_INIT    = 16'd3010;
  localparam logic [15:0] POINTER_BASE = 16'd3;
  localparam logic [15:0] TEMP_BASE    = 16'd5;
  localparam logic [15:0] STATIC_BASE  = 16'd16;
  localparam logic [15:0] BOTTOM_FRAME = 16'd256;
  localparam logic [15:0] FRAME_WORDS  = 16'd5;

  typedef enum logic [3:0] {
    K_NOP    = 4'd0,
    K_PUSH   = 4'd1,
    K_POP    = 4'd2,
    K_ADD    = 4'd3,
    K_SUB    = 4'd4,
    K_EQ     = 4'd5,
    K_NEG    = 4'd6,
    K_GT     = 4'd7,
    K_LT     = 4'd8,
    K_AND    = 4'd9,
    K_OR     = 4'd10,
    K_NOT    = 4'd11,
    K_GOTO   = 4'd12,
    K_IFGOTO = 4'd13,
    K_CALL   = 4'd14,
    K_RETURN = 4'd15
  } kind_e;

  typedef enum logic [2:0] {
    SEG_LOCAL    = 3'd0,
    SEG_ARGUMENT = 3'd1,
    SEG_OBJ      = 3'd2,
    SEG_ARR      = 3'd3,
    SEG_POINTER  = 3'd4,
    SEG_TEMP     = 3'd5,
    SEG_STATIC   = 3'd6,
    SEG_CONSTANT = 3'd7
  } segment_e;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_SEGMENT = 2'd1,
    FAULT_UNKNOWN = 2'd2
  } fault_e;

  typedef enum logic [2:0] {
    A_SEG  = 3'd0,
    A_SP   = 3'd1,
    A_SPM1 = 3'd2,
    A_ARG  = 3'd3,
    A_FRM  = 3'd4
  } asel_e;

  typedef enum logic [2:0] {
    D_RDV  = 3'd0,
    D_ALU  = 3'd1,
    D_OPND = 3'd2,
    D_FALL = 3'd3,
    D_PTR  = 3'd4,
    D_ZERO = 3'd5
  } dsel_e;

  typedef enum logic [1:0] {
    SP_NONE = 2'd0,
    SP_INC  = 2'd1,
    SP_DEC  = 2'd2,
    SP_ARG1 = 2'd3
  } spop_e;

  typedef enum logic [2:0] {
    N_KEEP    = 3'd0,
    N_OPND    = 3'd1,
    N_OPND_NZ = 3'd2,
    N_ENTRY   = 3'd3,
    N_RDV     = 3'd4
  } nsel_e;

  typedef struct packed {
    kind_e       kind;
    segment_e    segment;
    logic [14:0] operand;
    logic [15:0] fall_through;
    logic [15:0] callee_entry;
    logic [7:0]  callee_args;
    logic [7:0]  callee_locals;
  } req_t;

  typedef struct packed {
    logic [15:0] next_address;
    logic        halted;
    fault_e      fault;
  } res_t;

  typedef struct packed {
    logic       start;
    logic       clear;
    logic       rd;
    logic       wr;
    asel_e      asel;
    dsel_e      dsel;
    logic [2:0] idx;
    logic [2:0] fidx;
    logic       ld;
    spop_e      spop;
    logic       b_ld;
    logic       frm_ld;
    logic       call_set;
    logic       cnt_dec;
    nsel_e      nsel;
    logic       res_ld;
    logic       halted;
    fault_e     fault;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic cnt_zero;
    logic bottom;
  } stat_t;

endpackage

FILE: hdl/svce_ram.sv
// Generic single-port RAM with registered read data.
module svce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

FILE: hdl/svce_dpath.sv
// Datapath: pointer registers, address forming, ALU, word RAM and result register.
`include "assert_macros.svh"

module svce_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  svce_pkg::req_t  in_req_i,
  input  svce_pkg::cmd_t  cmd_i,
  output svce_pkg::stat_t stat_o,
  output svce_pkg::res_t  res_o
);

  import svce_pkg::*;

  req_t          req_q;
  res_t          res_q;
  logic [15:0]   ptr_q [NPTR];
  logic [15:0]   ptr_d [NPTR];
  logic [15:0]   b_q;
  logic [15:0]   frm_q;
  logic [15:0]   next_q;
  logic [15:0]   next_d;
  logic [7:0]    cnt_q;
  logic          rd_redir_q;
  logic [2:0]    rd_idx_q;
  logic [AW-1:0] clr_q;
  logic [15:0]   ram_rdata;
  logic [15:0]   rdv;
  logic [15:0]   seg_base;
  logic [15:0]   addr16;
  logic [AW-1:0] addr;
  logic          redir;
  logic [2:0]    redir_idx;
  logic [15:0]   alu;
  logic [15:0]   wdata;
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata;

  assign rdv = rd_redir_q ? ptr_q[rd_idx_q] : ram_rdata;

  always_comb begin
    unique case (req_q.segment)
      SEG_LOCAL:    seg_base = ptr_q[PTR_LCL];
      SEG_ARGUMENT: seg_base = ptr_q[PTR_ARG];
      SEG_OBJ:      seg_base = ptr_q[PTR_THIS];
      SEG_ARR:      seg_base = ptr_q[PTR_THAT];
      SEG_POINTER:  seg_base = POINTER_BASE;
      SEG_TEMP:     seg_base = TEMP_BASE;
      SEG_STATIC:   seg_base = STATIC_BASE;
      SEG_CONSTANT: seg_base = 16'd0;
    endcase
  end

  always_comb begin
    case (cmd_i.asel)
      A_SEG:   addr16 = seg_base + {1'b0, req_q.operand};
      A_SP:    addr16 = ptr_q[PTR_SP];
      A_SPM1:  addr16 = ptr_q[PTR_SP] - 16'd1;
      A_ARG:   addr16 = ptr_q[PTR_ARG];
      A_FRM:   addr16 = frm_q - {13'd0, cmd_i.fidx};
      default: addr16 = 16'd0;
    endcase
  end

  assign addr      = addr16[AW-1:0];
  assign redir     = (addr < AW'(NPTR));
  assign redir_idx = addr[2:0];

  always_comb begin
    unique case (req_q.kind)
      K_ADD:   alu = rdv + b_q;
      K_SUB:   alu = rdv - b_q;
      K_EQ:    alu = {16{rdv == b_q}};
      K_NEG:   alu = 16'd0 - rdv;
      K_GT:    alu = {16{$signed(rdv) > $signed(b_q)}};
      K_LT:    alu = {16{$signed(rdv) < $signed(b_q)}};
      K_AND:   alu = rdv & b_q;
      K_OR:    alu = rdv | b_q;
      K_NOT:   alu = ~rdv;
      default: alu = rdv;
    endcase
  end

  always_comb begin
    case (cmd_i.dsel)
      D_RDV:   wdata = rdv;
      D_ALU:   wdata = alu;
      D_OPND:  wdata = {1'b0, req_q.operand};
      D_FALL:  wdata = req_q.fall_through;
      D_PTR:   wdata = ptr_q[cmd_i.idx];
      default: wdata = 16'd0;
    endcase
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.wr && redir) begin
      ptr_d[redir_idx] = wdata;
    end
    if (cmd_i.ld) begin
      ptr_d[cmd_i.idx] = rdv;
    end
    if (cmd_i.call_set) begin
      ptr_d[PTR_ARG] = ptr_q[PTR_SP] - FRAME_WORDS - {8'd0, req_q.callee_args};
      ptr_d[PTR_LCL] = ptr_q[PTR_SP];
    end
    unique case (cmd_i.spop)
      SP_NONE: ;
      SP_INC:  ptr_d[PTR_SP] = ptr_q[PTR_SP] + 16'd1;
      SP_DEC:  ptr_d[PTR_SP] = ptr_q[PTR_SP] - 16'd1;
      SP_ARG1: ptr_d[PTR_SP] = ptr_q[PTR_ARG] + 16'd1;
    endcase
  end

  always_comb begin
    case (cmd_i.nsel)
      N_OPND:    next_d = {1'b0, req_q.operand};
      N_OPND_NZ: next_d = (rdv != 16'd0) ? {1'b0, req_q.operand} : next_q;
      N_ENTRY:   next_d = req_q.callee_entry;
      N_RDV:     next_d = rdv;
      default:   next_d = next_q;
    endcase
  end

  assign ram_en    = cmd_i.clear || cmd_i.rd || cmd_i.wr;
  assign ram_we    = cmd_i.clear || (cmd_i.wr && !redir);
  assign ram_addr  = cmd_i.clear ? clr_q : addr;
  assign ram_wdata = cmd_i.clear ? 16'd0 : wdata;

  svce_ram #(
    .WIDTH(DW),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q[PTR_SP]   <= SP_INIT;
      ptr_q[PTR_LCL]  <= LCL_INIT;
      ptr_q[PTR_ARG]  <= ARG_INIT;
      ptr_q[PTR_THIS] <= THIS_INIT;
      ptr_q[PTR_THAT] <= THAT_INIT;
      clr_q           <= '0;
      cnt_q           <= 8'd0;
      rd_redir_q      <= 1'b0;
      rd_idx_q        <= 3'd0;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.call_set) begin
        cnt_q <= req_q.callee_locals;
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - 8'd1;
      end
      if (cmd_i.rd) begin
        rd_redir_q <= redir;
        rd_idx_q   <= redir_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q  <= in_req_i;
      next_q <= in_req_i.fall_through;
    end else begin
      next_q <= next_d;
    end
    if (cmd_i.b_ld) begin
      b_q <= rdv;
    end
    if (cmd_i.frm_ld) begin
      frm_q <= ptr_q[PTR_LCL];
    end
    if (cmd_i.res_ld) begin
      res_q.next_address <= next_q;
      res_q.halted       <= cmd_i.halted;
      res_q.fault        <= cmd_i.fault;
    end
  end

  assign stat_o.clr_done = (clr_q == '1);
  assign stat_o.cnt_zero = (cnt_q == 8'd0);
  assign stat_o.bottom   = (ptr_q[PTR_LCL] <= BOTTOM_FRAME);
  assign res_o           = res_q;

  `SVCE_NEVER(a_single_port, (cmd_i.rd && cmd_i.wr) || (cmd_i.clear && (cmd_i.rd || cmd_i.wr)), "two RAM accesses in one cycle")
  `SVCE_ASSERT(a_pop_moves_sp, (cmd_i.spop == SP_DEC) |=> (ptr_q[PTR_SP] == $past(ptr_q[PTR_SP]) - 16'd1), "stack pointer not decremented by pop")

endmodule

FILE: hdl/svce_ctrl.sv
// Controller: sequences each command into RAM and register steps for the datapath.
`include "assert_macros.svh"

module svce_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  svce_pkg::kind_e    in_kind_i,
  input  svce_pkg::segment_e in_segment_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output svce_pkg::cmd_t     cmd_o,
  input  svce_pkg::stat_t    stat_i
);

  import svce_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_RUN    = 5'b00100,
    S_FILL   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e   state_q, state_d;
  kind_e    kind_q;
  segment_e seg_q;
  logic [3:0] step_q, step_d;
  logic     halt_q, halt_d;
  logic     out_valid_q, out_valid_d;
  logic     last;

  always_comb begin
    cmd_o   = '0;
    last    = 1'b0;
    state_d = state_q;
    step_d  = step_q;
    halt_d  = halt_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          step_d      = 4'd0;
          halt_d      = 1'b0;
          state_d     = S_RUN;
        end
      end
      S_RUN: begin
        step_d = step_q + 4'd1;
        unique case (kind_q)
          K_NOP: begin
            last = 1'b1;
          end
          K_PUSH: begin
            if (seg_q == SEG_CONSTANT) begin
              cmd_o.wr   = 1'b1;
              cmd_o.asel = A_SP;
              cmd_o.dsel = D_OPND;
              cmd_o.spop = SP_INC;
              last       = 1'b1;
            end else if (step_q == 4'd0) begin
              cmd_o.rd   = 1'b1;
              cmd_o.asel = A_SEG;
            end else begin
              cmd_o.wr   = 1'b1;
              cmd_o.asel = A_SP;
              cmd_o.dsel = D_RDV;
              cmd_o.spop = SP_INC;
              last       = 1'b1;
            end
          end
          K_POP: begin
            if (seg_q == SEG_CONSTANT) begin
              last = 1'b1;
            end else if (step_q == 4'd0) begin
              cmd_o.rd   = 1'b1;
              cmd_o.asel = A_SPM1;
              cmd_o.spop = SP_DEC;
            end else begin
              cmd_o.wr   = 1'b1;
              cmd_o.asel = A_SEG;
              cmd_o.dsel = D_RDV;
              last       = 1'b1;
            end
          end
          K_ADD, K_SUB, K_EQ, K_GT, K_LT, K_AND, K_OR: begin
            if (step_q == 4'd0) begin
              cmd_o.rd   = 1'b1;
              cmd_o.asel = A_SPM1;
              cmd_o.spop = SP_DEC;
            end else if (step_q == 4'd1) begin
              cmd_o.b_ld = 1'b1;
              cmd_o.rd   = 1'b1;
              cmd_o.asel = A_SPM1;
              cmd_o.spop = SP_DEC;
            end else begin
              cmd_o.wr   = 1'b1;
              cmd_o.asel = A_SP;
              cmd_o.dsel = D_ALU;
              cmd_o.spop = SP_INC;
              last       = 1'b1;
            end
          end
          K_NEG, K_NOT: begin
            if (step_q == 4'd0) begin
              cmd_o.rd   = 1'b1;
              cmd_o.asel = A_SPM1;
              cmd_o.spop = SP_DEC;
            end else begin
              cmd_o.wr   = 1'b1;
              cmd_o.asel = A_SP;
              cmd_o.dsel = D_ALU;
              cmd_o.spop = SP_INC;
              last       = 1'b1;
            end
          end
          K_GOTO: begin
            cmd_o.nsel = N_OPND;
            last       = 1'b1;
          end
          K_IFGOTO: begin
            if (step_q == 4'd0) begin
              cmd_o.rd   = 1'b1;
              cmd_o.asel = A_SPM1;
              cmd_o.spop = SP_DEC;
            end else begin
              cmd_o.nsel = N_OPND_NZ;
              last       = 1'b1;
            end
          end
          K_CALL: begin
            if (step_q < 4'd5) begin
              cmd_o.wr   = 1'b1;
              cmd_o.asel = A_SP;
              cmd_o.dsel = (step_q == 4'd0) ? D_FALL : D_PTR;
              cmd_o.idx  = step_q[2:0];
              cmd_o.spop = SP_INC;
            end else begin
              cmd_o.call_set = 1'b1;
              cmd_o.nsel     = N_ENTRY;
              last           = 1'b1;
            end
          end
          K_RETURN: begin
            unique case (step_q)
              4'd0: begin
                cmd_o.frm_ld = 1'b1;
                if (stat_i.bottom) begin
                  halt_d = 1'b1;
                  last   = 1'b1;
                end
              end
              4'd1: begin
                cmd_o.rd   = 1'b1;
                cmd_o.asel = A_FRM;
                cmd_o.fidx = 3'd5;
              end
              4'd2: begin
                cmd_o.nsel = N_RDV;
                cmd_o.rd   = 1'b1;
                cmd_o.asel = A_SPM1;
                cmd_o.spop = SP_DEC;
              end
              4'd3: begin
                cmd_o.wr   = 1'b1;
                cmd_o.asel = A_ARG;
                cmd_o.dsel = D_RDV;
              end
              4'd4: begin
                cmd_o.spop = SP_ARG1;
                cmd_o.rd   = 1'b1;
                cmd_o.asel = A_FRM;
                cmd_o.fidx = 3'd1;
              end
              // The return steps that load THAT, THIS and ARG also start the next frame read.
              4'd5: begin
                cmd_o.ld   = 1'b1;
                cmd_o.idx  = PTR_THAT;
                cmd_o.rd   = 1'b1;
                cmd_o.asel = A_FRM;
                cmd_o.fidx = 3'd2;
              end
              4'd6: begin
                cmd_o.ld   = 1'b1;
                cmd_o.idx  = PTR_THIS;
                cmd_o.rd   = 1'b1;
                cmd_o.asel = A_FRM;
                cmd_o.fidx = 3'd3;
              end
              4'd7: begin
                cmd_o.ld   = 1'b1;
                cmd_o.idx  = PTR_ARG;
                cmd_o.rd   = 1'b1;
                cmd_o.asel = A_FRM;
                cmd_o.fidx = 3'd4;
              end
              default: begin
                cmd_o.ld  = 1'b1;
                cmd_o.idx = PTR_LCL;
                last      = 1'b1;
              end
            endcase
          end
        endcase
        if (last) begin
          state_d = (kind_q == K_CALL) ? S_FILL : S_FINISH;
        end
      end
      S_FILL: begin
        if (stat_i.cnt_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.wr      = 1'b1;
          cmd_o.asel    = A_SP;
          cmd_o.dsel    = D_ZERO;
          cmd_o.spop    = SP_INC;
          cmd_o.cnt_dec = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.halted = halt_q;
          cmd_o.fault  = (kind_q == K_POP && seg_q == SEG_CONSTANT) ? FAULT_SEGMENT
                                                                    : FAULT_NONE;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= 4'd0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= K_NOP;
      seg_q       <= SEG_LOCAL;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      halt_q      <= halt_d;
      out_valid_q <= out_valid_d;
      if (cmd_o.start) begin
        kind_q <= in_kind_i;
        seg_q  <= in_segment_i;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `SVCE_ASSERT(a_no_result_overwrite, cmd_o.res_ld |-> (!out_valid_q || out_ready_i), "pending result overwritten")
  `SVCE_ASSERT(a_accept_starts_run, (in_valid_i && in_ready_o) |=> (state_q == S_RUN), "accepted request did not start")
  `SVCE_NEVER(a_no_accept_in_clear, (state_q == S_CLEAR) && in_ready_o, "request accepted during RAM clear")

endmodule

FILE: hdl/stack_vm_command_executor.sv
// Top level of the stack machine command executor.
// One request on the in channel carries a decoded stack machine command; each request
// gives exactly one result on the out channel: next code address, halt flag and fault.
// The stack lives in a single-port word RAM; the five pointers (SP, LCL, ARG, THIS,
// THAT) are kept in registers and RAM words 0 to 4 map onto them.
// Each command runs as a sequence of RAM and register steps before its result is
// registered; call also zeroes one stack word per local, and return from the bottom
// frame sets the halt flag and ends after its first step.
// in_ready_o rises in the cycle after the result is registered, so a request is
// through before the next is taken; the single RAM port is why commands take steps.
// After reset all 32768 RAM words are cleared, one word per cycle, with in_ready_o low.
// The result sits in an output register; while the receiver stalls the block still
// accepts and runs one more request and then holds until the register is free.
module stack_vm_command_executor (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  svce_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output svce_pkg::res_t out_res_o
);

  import svce_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  svce_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_kind_i    (in_req_i.kind),
    .in_segment_i (in_req_i.segment),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  svce_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (in_req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .res_o    (out_res_o)
  );

endmodule
